@@ src/interval_insert_merge_core_macros.svh @@
// Assertion macros shared by the interval insert/merge core modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INTERVAL_INSERT_MERGE_CORE_MACROS_SVH
`define INTERVAL_INSERT_MERGE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define IIM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("iim assertion failed");

// next-cycle implication, disabled in reset
`define IIM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("iim assertion failed");

`endif

@@ src/iim_pkg.sv @@
// Types and constants for the interval insert/merge core.
// No dependencies; imported by every module of the block.
package iim_pkg;

    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int QUEUE_DEPTH_D = 2;

    localparam logic OP_INTERVAL = 1'b0;
    localparam logic OP_FLUSH    = 1'b1;

    localparam logic REG_NEW_START = 1'b0;
    localparam logic REG_NEW_END   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] interval_start;
        logic signed [31:0] interval_end;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] merged_start;
        logic signed [31:0] merged_end;
        logic               last_of_list;
        logic               last_of_run;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] new_start;
        logic signed [31:0] new_end;
    } cfg_t;

    // classified item as held in the queue
    typedef struct packed {
        logic               is_flush;
        logic               new_first;  // configured interval goes ahead of this one
        logic signed [31:0] start_val;
        logic signed [31:0] end_val;
    } cmd_t;

endpackage

@@ src/iim_front.sv @@
// Front end: accepts input words, classifies them and queues them.
// Depends on iim_pkg and the assertion macros header.
`include "interval_insert_merge_core_macros.svh"

module iim_front
    import iim_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     q_valid,
    input  logic     q_pop,
    output cmd_t     q_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cls;
    logic             push;
    logic             pop;

    always_comb begin
        cls.is_flush  = (s_data.opcode == OP_FLUSH);
        cls.new_first = (cfg.new_start <= s_data.interval_start);
        cls.start_val = s_data.interval_start;
        cls.end_val   = s_data.interval_end;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    `IIM_ASSERT_NEXT(a_fill_to_full, aclk, aresetn,
        push && !pop && (count_reg == CNT_W'(QUEUE_DEPTH - 1)), !s_ready)

endmodule

@@ src/iim_back.sv @@
// Back end: merges queued words into the open interval and drives results.
// Depends on iim_pkg and the assertion macros header.
`include "interval_insert_merge_core_macros.svh"

module iim_back
    import iim_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_pop,
    input  cmd_t      q_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic signed [31:0] open_start_reg, open_start_next;
    logic signed [31:0] open_end_reg, open_end_next;
    logic               have_open_reg, have_open_next;
    logic               placed_reg, placed_next;
    out_word_t          out_reg;
    logic               out_valid_reg;
    out_word_t          pend_reg;
    logic               pend_valid_reg;

    logic               place_a;
    logic               emit_a, emit_b;
    out_word_t          res_a, res_b;
    logic signed [31:0] os_a, oe_a;
    logic               h_a;
    out_word_t          r0, r1;
    logic               emit_any, emit_two;
    logic               can_take, pop, out_take;

    always_comb begin
        // configured interval first, if due
        place_a = q_cmd.is_flush ? !placed_reg : (!placed_reg && q_cmd.new_first);
        os_a    = open_start_reg;
        oe_a    = open_end_reg;
        h_a     = have_open_reg;
        emit_a  = 1'b0;
        res_a   = '{open_start_reg, open_end_reg, 1'b0, 1'b0};
        if (place_a) begin
            if (have_open_reg && (cfg.new_start <= open_end_reg)) begin
                oe_a = (cfg.new_end > open_end_reg) ? cfg.new_end : open_end_reg;
            end else begin
                emit_a = have_open_reg;
                os_a   = cfg.new_start;
                oe_a   = cfg.new_end;
                h_a    = 1'b1;
            end
        end

        // then the word itself
        res_b           = '{os_a, oe_a, q_cmd.is_flush, 1'b1};
        open_start_next = os_a;
        open_end_next   = oe_a;
        have_open_next  = h_a;
        placed_next     = placed_reg || place_a;
        emit_b          = 1'b0;
        if (q_cmd.is_flush) begin
            emit_b          = h_a;
            open_start_next = '0;
            open_end_next   = '0;
            have_open_next  = 1'b0;
            placed_next     = 1'b0;
        end else if (h_a && (q_cmd.start_val <= oe_a)) begin
            open_end_next = (q_cmd.end_val > oe_a) ? q_cmd.end_val : oe_a;
        end else begin
            emit_b          = h_a;
            open_start_next = q_cmd.start_val;
            open_end_next   = q_cmd.end_val;
            have_open_next  = 1'b1;
        end

        emit_any = emit_a || emit_b;
        emit_two = emit_a && emit_b;
        r1       = res_b;
        if (emit_a) begin
            r0             = res_a;
            r0.last_of_run = !emit_b;
        end else begin
            r0 = res_b;
        end
    end

    assign out_take = out_valid_reg && m_ready;
    assign can_take = !pend_valid_reg && (!out_valid_reg || m_ready);
    assign pop      = q_valid && can_take;
    assign q_pop    = pop;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_start_reg <= '0;
            open_end_reg   <= '0;
            have_open_reg  <= 1'b0;
            placed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (pop) begin
            open_start_reg <= open_start_next;
            open_end_reg   <= open_end_next;
            have_open_reg  <= have_open_next;
            placed_reg     <= placed_next;
            if (emit_any) begin
                out_valid_reg <= 1'b1;
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
            pend_valid_reg <= emit_two;
        end else if (out_take) begin
            if (pend_valid_reg) begin
                pend_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (emit_any) begin
                out_reg <= r0;
            end
            pend_reg <= r1;
        end else if (out_take && pend_valid_reg) begin
            out_reg <= pend_reg;
        end
    end

    // second result of a word only ever waits behind a shown first one
    `IIM_ASSERT_NOW(a_pend_behind_out, aclk, aresetn, pend_valid_reg, out_valid_reg)
    `IIM_ASSERT_NEXT(a_two_results_pend, aclk, aresetn, pop && emit_two,
        pend_valid_reg && out_valid_reg)
    `IIM_ASSERT_NEXT(a_flush_clears, aclk, aresetn, pop && q_cmd.is_flush,
        !have_open_reg && !placed_reg)

endmodule

@@ src/interval_insert_merge_core.sv @@
// Interval insert/merge core: one word accepted per cycle when results drain.
// Path: an accepted word is written into the queue, then popped by the back end into the output register.
// Throughput: one word per cycle while results drain; a word with two results holds off
// the next word while its second result waits in the spare slot behind the single output register.
// Reset: synchronous, active low; clears queue, open interval and registers.
// Holds the APB registers; depends on iim_pkg, iim_front and iim_back.
module interval_insert_merge_core
    import iim_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);

    cfg_t cfg_reg;
    logic cfg_wr;
    logic reg_sel;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_NEW_START: cfg_reg.new_start <= pwdata;
                REG_NEW_END:   cfg_reg.new_end   <= pwdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NEW_START: prdata = cfg_reg.new_start;
            REG_NEW_END:   prdata = cfg_reg.new_end;
            default:       prdata = '0;
        endcase
    end

    iim_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    iim_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
